/* hw/rtl/ledfx_pkg.sv */
// shared types and codes for the led indicator effect engine
// per-led entry layout, phase and mode codes, request and result structs
// no dependencies
package ledfx_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DELAY = 2'd1,
    PH_ON    = 2'd2,
    PH_OFF   = 2'd3
  } phase_t;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_BLINK = 2'd2;
  // unused code, handled as off
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 24;
  localparam int MAP_W      = 8;
  localparam int NOTE_W     = 4;

  // one led's stored state, one memory word
  typedef struct packed {
    phase_t      phase;
    logic        lit;
    logic [7:0]  blink_done;
    logic [15:0] elapsed_ms;
    logic [15:0] period_ms;
    logic [1:0]  stored_mode;
    logic [15:0] stored_on;
    logic [15:0] stored_off;
    logic [15:0] stored_duration;
    logic [7:0]  stored_repeat;
  } entry_t;

  // effect load request taken from the input transaction
  typedef struct packed {
    logic        do_set;
    logic [1:0]  effect_mode;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [15:0] start_delay;
    logic [15:0] on_duration;
    logic [7:0]  repeat_count;
  } set_req_t;

  typedef struct packed {
    entry_t entry;
    logic   note;
  } upd_res_t;

endpackage

/* hw/rtl/ledfx_mem.sv */
// per-led state memory, one write and one registered read port
// entries read as zero until first written; uses ledfx_pkg
module ledfx_mem #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  ledfx_pkg::entry_t    wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output ledfx_pkg::entry_t    rd_data
);

  ledfx_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0]  valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  // valid bits stand in for the all-zero reset of the entries
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule

/* hw/rtl/ledfx_update.sv */
// next-state logic for one led entry: effect load or one millisecond tick
// combinational, uses ledfx_pkg
module ledfx_update (
  input  ledfx_pkg::set_req_t req,
  input  ledfx_pkg::entry_t   old_entry,
  output ledfx_pkg::upd_res_t res
);

  function automatic ledfx_pkg::upd_res_t advance(input ledfx_pkg::entry_t e);
    ledfx_pkg::upd_res_t r;
    logic [7:0] bd;
    r.entry = e;
    r.note  = 1'b0;
    bd      = e.blink_done + 8'd1;
    case (e.phase)
      ledfx_pkg::PH_DELAY: begin
        if (e.stored_mode == ledfx_pkg::MODE_ON) begin
          r.entry.lit = 1'b1;
          if (e.stored_duration != 16'd0) begin
            r.entry.phase     = ledfx_pkg::PH_ON;
            r.entry.period_ms = e.stored_duration;
          end else begin
            r.entry.phase     = ledfx_pkg::PH_IDLE;
            r.entry.period_ms = '0;
          end
        end else if (e.stored_mode == ledfx_pkg::MODE_BLINK) begin
          r.entry.lit        = 1'b1;
          r.entry.blink_done = '0;
          r.entry.phase      = ledfx_pkg::PH_ON;
          r.entry.period_ms  = e.stored_on;
        end else begin
          r.entry.lit       = 1'b0;
          r.entry.phase     = ledfx_pkg::PH_IDLE;
          r.entry.period_ms = '0;
        end
      end
      ledfx_pkg::PH_ON: begin
        r.entry.lit = 1'b0;
        if (e.stored_mode == ledfx_pkg::MODE_BLINK) begin
          r.entry.blink_done = bd;
          if (e.stored_repeat != 8'd0 && bd >= e.stored_repeat) begin
            r.entry.phase     = ledfx_pkg::PH_IDLE;
            r.entry.period_ms = '0;
            r.note            = 1'b1;
          end else begin
            r.entry.phase     = ledfx_pkg::PH_OFF;
            r.entry.period_ms = e.stored_off;
          end
        end else begin
          r.entry.phase     = ledfx_pkg::PH_IDLE;
          r.entry.period_ms = '0;
          r.note            = 1'b1;
        end
      end
      ledfx_pkg::PH_OFF: begin
        r.entry.lit       = 1'b1;
        r.entry.phase     = ledfx_pkg::PH_ON;
        r.entry.period_ms = e.stored_on;
      end
      default: begin
        r.entry.period_ms = '0;
      end
    endcase
    r.entry.elapsed_ms = '0;
    return r;
  endfunction

  ledfx_pkg::entry_t ld;
  ledfx_pkg::entry_t tk;
  logic [15:0]       el;
  logic [1:0]        mode;

  always_comb begin
    // effect load, mode three acts as off
    mode = (req.effect_mode == ledfx_pkg::MODE_ON ||
            req.effect_mode == ledfx_pkg::MODE_BLINK) ? req.effect_mode
                                                      : ledfx_pkg::MODE_OFF;
    ld                 = '0;
    ld.stored_mode     = mode;
    ld.stored_on       = req.on_time;
    ld.stored_off      = req.off_time;
    ld.stored_duration = req.on_duration;
    ld.stored_repeat   = req.repeat_count;
    ld.phase           = ledfx_pkg::PH_DELAY;
    ld.period_ms       = req.start_delay;

    // tick, elapsed count saturates
    tk = old_entry;
    el = (old_entry.elapsed_ms != 16'hFFFF) ? old_entry.elapsed_ms + 16'd1
                                            : old_entry.elapsed_ms;
    tk.elapsed_ms = el;

    if (req.do_set) begin
      if (mode == ledfx_pkg::MODE_OFF) begin
        ld.phase     = ledfx_pkg::PH_IDLE;
        ld.period_ms = '0;
        res.entry    = ld;
        res.note     = 1'b1;
      end else if (req.start_delay != 16'd0) begin
        res.entry = ld;
        res.note  = 1'b0;
      end else begin
        res = advance(ld);
      end
    end else if (old_entry.phase != ledfx_pkg::PH_IDLE &&
                 old_entry.period_ms != 16'd0) begin
      if (el >= old_entry.period_ms) begin
        res = advance(tk);
      end else begin
        res.entry = tk;
        res.note  = 1'b0;
      end
    end else begin
      res.entry = old_entry;
      res.note  = 1'b0;
    end
  end

endmodule

/* hw/rtl/led_indicator_effect_engine_core.sv */
// top level of the led indicator effect engine: stream ports, sequencer,
// lit and active maps; uses ledfx_pkg, ledfx_mem, ledfx_update
//
// channel  direction  handshake          payload
// s        in         s_tvalid/s_tready  s_tuser func, s_tdata effect fields
// m        out        m_tvalid/m_tready  m_tdata lit, active, notes, all off
//
// a set transaction writes its led entry at acceptance, result registered from
// the finish state; a tick walks the state memory, one led read per cycle with read-modify-write
// in the cycle after each read; next transaction accepted only back in idle
// the walk length is set by the single read port of the state memory
// rst is synchronous; memory entries read as zero until first written
// a result waits in the output register while the next transaction is taken
module led_indicator_effect_engine_core #(
  parameter int LED_COUNT = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // led_index[2:0], effect_mode[4:3], on_time[20:5], off_time[36:21],
  // start_delay[52:37], on_duration[68:53], repeat_count[76:69], zero[79:77]
  input  logic [ledfx_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // lit_map[7:0], active_map[15:8], lowpower_calls[19:16], all_off[20],
  // zero[23:21]
  output logic [ledfx_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int CNT_W = $clog2(LED_COUNT + 1) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t                        state;
  logic [CNT_W-1:0]              cnt;
  logic                          pend;
  logic [IDX_W-1:0]              pend_idx;
  logic [ledfx_pkg::NOTE_W-1:0]  notes;
  logic [LED_COUNT-1:0]          lit_map;
  logic [LED_COUNT-1:0]          act_map;

  logic                          accept;
  logic                          is_set;
  logic                          in_range;
  logic [2:0]                    led_index;
  ledfx_pkg::set_req_t           req;
  ledfx_pkg::entry_t             rd_data;
  ledfx_pkg::upd_res_t           res;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic [ledfx_pkg::MAP_W-1:0]   lit8;
  logic [ledfx_pkg::MAP_W-1:0]   act8;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign is_set    = (s_tuser == ledfx_pkg::FUNC_SET);
  assign led_index = s_tdata[2:0];
  assign in_range  = (32'(led_index) < LED_COUNT);

  // set fields go straight from the port; walk cycles run the tick path
  always_comb begin
    req.do_set       = (state == ST_IDLE);
    req.effect_mode  = s_tdata[4:3];
    req.on_time      = s_tdata[20:5];
    req.off_time     = s_tdata[36:21];
    req.start_delay  = s_tdata[52:37];
    req.on_duration  = s_tdata[68:53];
    req.repeat_count = s_tdata[76:69];
  end

  // write at set acceptance or in the cycle after each walk read
  assign wr_en   = (accept && is_set && in_range) || (state == ST_WALK && pend);
  assign wr_addr = (state == ST_IDLE) ? led_index[IDX_W-1:0] : pend_idx;
  assign rd_en   = (state == ST_WALK) && (cnt < CNT_W'(LED_COUNT));
  assign rd_addr = cnt[IDX_W-1:0];

  assign lit8 = ledfx_pkg::MAP_W'(lit_map);
  assign act8 = ledfx_pkg::MAP_W'(act_map);

  ledfx_mem #(
    .DEPTH  (LED_COUNT),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (res.entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ledfx_update u_update (
    .req       (req),
    .old_entry (rd_data),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      pend     <= 1'b0;
      pend_idx <= '0;
      notes    <= '0;
      lit_map  <= '0;
      act_map  <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      // keep the maps in step with every entry write
      if (wr_en) begin
        lit_map[wr_addr] <= res.entry.lit;
        act_map[wr_addr] <= (res.entry.phase != ledfx_pkg::PH_IDLE) || res.entry.lit;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt  <= '0;
            pend <= 1'b0;
            if (is_set) begin
              notes <= (in_range && res.note) ? ledfx_pkg::NOTE_W'(1) : '0;
              state <= ST_FINISH;
            end else begin
              notes <= '0;
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (pend) begin
            notes <= notes + ledfx_pkg::NOTE_W'(res.note);
          end
          if (rd_en) begin
            pend     <= 1'b1;
            pend_idx <= rd_addr;
            cnt      <= cnt + CNT_W'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, (act_map == '0), notes, act8, lit8};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // the walk never reads the entry that is being written back
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of the same entry in one cycle");

  a_notes_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(notes) <= LED_COUNT))
    else $error("notification count above led count");

  a_lit_active: assert property (@(posedge clk) disable iff (rst)
    ((lit_map & ~act_map) == '0))
    else $error("lit led not marked active");

  a_all_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[20] == (m_tdata[15:8] == 8'd0)))
    else $error("all off flag disagrees with active map");

  a_walk_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (cnt <= CNT_W'(LED_COUNT)))
    else $error("walk counter past led count");
`endif

endmodule
